// ----- design/plrc_pkg.sv -----
// Shared types, codes and packet byte tables for the packet layer restart controller.
package plrc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENDED_SEQ    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESTART_TIMEOUT = 1'b1;
  localparam int CFG_DATA_W = 16;

  // Reset value of the restart timeout configuration register
  localparam logic [15:0] RESTART_TIMEOUT_RESET = 16'd180;

  // General format identifiers and packet type bytes
  localparam logic [7:0] GFI_MOD8           = 8'h10;
  localparam logic [7:0] GFI_MOD128         = 8'h20;
  localparam logic [7:0] PTYPE_RESTART_REQ  = 8'hFB;
  localparam logic [7:0] PTYPE_RESTART_CONF = 8'hFF;
  localparam logic [7:0] PTYPE_DIAGNOSTIC   = 8'hF1;
  localparam logic [7:0] PTYPE_CLEAR_REQ    = 8'h13;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_CONTROL = 3'd1,
    OP_SEND    = 3'd2,
    OP_DIAG    = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_CTRL = 2'd1,
    KIND_DROP = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PKT_REQ   = 2'd0,
    PKT_CONF  = 2'd1,
    PKT_DIAG  = 2'd2,
    PKT_CLEAR = 2'd3
  } pkt_sel_t;

  typedef enum logic [1:0] {
    SRC_CTRL  = 2'd0,
    SRC_FRAME = 2'd1,
    SRC_DRAIN = 2'd2
  } out_src_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SINGLE,
    ST_PKT,
    ST_DRAIN_RD,
    ST_DRAIN_OUT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       capture;
    logic       tick;
    logic       restart_ack;
    logic       link_update;
    logic       enqueue;
    logic       reload;
    logic       pop;
    logic       out_load;
    out_src_t   out_src;
    kind_t      out_kind;
    logic       out_last;
    pkt_sel_t   pkt_sel;
    logic [2:0] byte_idx;
  } plrc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_t  op;
    logic ptype_req;
    logic ptype_conf;
    logic link_up;
    logic link_ready;
    logic cd_zero;
    logic cd_one;
    logic q_empty;
    logic q_one;
    logic q_full;
    logic out_free;
  } plrc_status_t;

  // Index of the final byte of each control packet
  function automatic logic [2:0] pkt_last_idx(pkt_sel_t sel);
    logic [2:0] n;
    case (sel)
      PKT_REQ:   n = 3'd4;
      PKT_CONF:  n = 3'd2;
      PKT_DIAG:  n = 3'd3;
      PKT_CLEAR: n = 3'd4;
      default:   n = 3'd4;
    endcase
    return n;
  endfunction

  // Byte of a control packet at a given position
  function automatic logic [7:0] pkt_byte(pkt_sel_t sel, logic [2:0] idx, logic [7:0] gfi,
                                          logic [7:0] diag, logic [11:0] lci,
                                          logic [7:0] cause);
    logic [7:0] b;
    b = 8'h00;
    case (sel)
      PKT_REQ: begin
        case (idx)
          3'd0:    b = gfi;
          3'd2:    b = PTYPE_RESTART_REQ;
          default: b = 8'h00;
        endcase
      end
      PKT_CONF: begin
        case (idx)
          3'd0:    b = gfi;
          3'd2:    b = PTYPE_RESTART_CONF;
          default: b = 8'h00;
        endcase
      end
      PKT_DIAG: begin
        case (idx)
          3'd0:    b = gfi;
          3'd2:    b = PTYPE_DIAGNOSTIC;
          3'd3:    b = diag;
          default: b = 8'h00;
        endcase
      end
      PKT_CLEAR: begin
        case (idx)
          3'd0:    b = gfi | {4'h0, lci[11:8]};
          3'd1:    b = lci[7:0];
          3'd2:    b = PTYPE_CLEAR_REQ;
          3'd3:    b = cause;
          default: b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- design/plrc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module plrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/plrc_dp.sv -----
// Datapath: link state, T20 timer, pending frame queue, configuration and output register.
module plrc_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [plrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [plrc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [2:0]                        in_op,
  input  logic [7:0]                        in_packet_type,
  input  logic [7:0]                        in_frame_handle,
  input  logic                              in_link_up,
  input  logic [7:0]                        in_diag_code,
  input  logic [11:0]                       in_channel_id,
  input  logic [7:0]                        in_clear_cause,
  input  plrc_pkg::plrc_cmd_t               cmd,
  output plrc_pkg::plrc_status_t            status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_kind,
  output logic [7:0]                        out_packet_byte,
  output logic [7:0]                        out_released_handle,
  output logic                              out_last
);
  import plrc_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] HEAD_MAX   = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_SUM  = (IDX_W + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] COUNT_ONE  = CNT_W'(1);

  // Configuration registers
  logic        ext_seq_r;
  logic [15:0] timeout_r;

  // Link, timer and queue control state
  logic             link_ready_r, link_ready_nxt;
  logic [15:0]      countdown_r, countdown_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Captured input item
  logic [2:0]  op_r;
  logic [7:0]  ptype_r;
  logic [7:0]  handle_r;
  logic        link_up_r;
  logic [7:0]  diag_r;
  logic [11:0] lci_r;
  logic [7:0]  cause_r;

  // Output register
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_byte_r;
  logic [7:0]  out_handle_r;
  logic        out_last_r;

  logic [IDX_W:0]   tail_sum;
  logic [IDX_W-1:0] tail_idx;
  logic [7:0]       ram_rdata;
  logic [7:0]       gfi;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_seq_r <= 1'b0;
      timeout_r <= RESTART_TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXTENDED_SEQ:    ext_seq_r <= cfg_data[0];
        CFG_RESTART_TIMEOUT: timeout_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign gfi = ext_seq_r ? GFI_MOD128 : GFI_MOD8;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_op;
      ptype_r   <= in_packet_type;
      handle_r  <= in_frame_handle;
      link_up_r <= in_link_up;
      diag_r    <= in_diag_code;
      lci_r     <= in_channel_id;
      cause_r   <= in_clear_cause;
    end
  end

  // Queue write slot: head plus count, wrapped at the depth
  assign tail_sum = {1'b0, head_r} + {1'b0, count_r[IDX_W-1:0]};
  assign tail_idx = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM)
                                            : IDX_W'(tail_sum);

  // Next link, timer and queue state
  always_comb begin
    link_ready_nxt = link_ready_r;
    countdown_nxt  = countdown_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    if (cmd.tick && (countdown_r != 16'd0)) begin
      countdown_nxt = (countdown_r == 16'd1) ? timeout_r : countdown_r - 16'd1;
    end
    if (cmd.restart_ack) begin
      countdown_nxt  = 16'd0;
      link_ready_nxt = 1'b1;
    end
    if (cmd.link_update) begin
      link_ready_nxt = link_ready_r & link_up_r;
    end
    if (cmd.reload) begin
      countdown_nxt = timeout_r;
    end
    if (cmd.enqueue) begin
      count_nxt = count_r + COUNT_ONE;
    end
    if (cmd.pop) begin
      head_nxt  = (head_r == HEAD_MAX) ? '0 : head_r + IDX_W'(1);
      count_nxt = count_r - COUNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_ready_r <= 1'b0;
      countdown_r  <= 16'd0;
      head_r       <= '0;
      count_r      <= '0;
    end else begin
      link_ready_r <= link_ready_nxt;
      countdown_r  <= countdown_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
    end
  end

  // Pending frame storage, read at the head every cycle
  plrc_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (cmd.enqueue),
    .waddr (tail_idx),
    .wdata (handle_r),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // Load a result, or retire the one that was transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r <= cmd.out_kind;
      out_last_r <= cmd.out_last;
      case (cmd.out_src)
        SRC_CTRL: begin
          out_byte_r   <= pkt_byte(cmd.pkt_sel, cmd.byte_idx, gfi, diag_r, lci_r, cause_r);
          out_handle_r <= 8'h00;
        end
        SRC_FRAME: begin
          out_byte_r   <= 8'h00;
          out_handle_r <= handle_r;
        end
        SRC_DRAIN: begin
          out_byte_r   <= 8'h00;
          out_handle_r <= ram_rdata;
        end
        default: begin
          out_byte_r   <= 8'h00;
          out_handle_r <= 8'h00;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_packet_byte     = out_byte_r;
  assign out_released_handle = out_handle_r;
  assign out_last            = out_last_r;

  // Report status to the controller
  assign status.op         = op_t'(op_r);
  assign status.ptype_req  = (ptype_r == PTYPE_RESTART_REQ);
  assign status.ptype_conf = (ptype_r == PTYPE_RESTART_CONF);
  assign status.link_up    = link_up_r;
  assign status.link_ready = link_ready_r;
  assign status.cd_zero    = (countdown_r == 16'd0);
  assign status.cd_one     = (countdown_r == 16'd1);
  assign status.q_empty    = (count_r == '0);
  assign status.q_one      = (count_r == COUNT_ONE);
  assign status.q_full     = (count_r == COUNT_FULL);
  assign status.out_free   = !out_valid_r || out_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_FULL)
    else $error("pending count beyond queue depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= HEAD_MAX)
    else $error("queue head out of range");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

// ----- design/plrc_ctrl.sv -----
// Controller: sequences one item through decide, result emission and queue drain.
module plrc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  plrc_pkg::plrc_status_t status,
  output plrc_pkg::plrc_cmd_t    cmd
);
  import plrc_pkg::*;

  state_t     state_r, state_nxt;
  pkt_sel_t   pkt_sel_r, pkt_sel_nxt;
  logic [2:0] byte_idx_r, byte_idx_nxt;
  kind_t      single_kind_r, single_kind_nxt;
  logic       pkt_pend_r, pkt_pend_nxt;
  logic       drain_pend_r, drain_pend_nxt;
  logic       pkt_at_end;

  // State and sequencing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pkt_sel_r     <= PKT_REQ;
      byte_idx_r    <= 3'd0;
      single_kind_r <= KIND_DATA;
      pkt_pend_r    <= 1'b0;
      drain_pend_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pkt_sel_r     <= pkt_sel_nxt;
      byte_idx_r    <= byte_idx_nxt;
      single_kind_r <= single_kind_nxt;
      pkt_pend_r    <= pkt_pend_nxt;
      drain_pend_r  <= drain_pend_nxt;
    end
  end

  assign pkt_at_end = (byte_idx_r == pkt_last_idx(pkt_sel_r));
  assign in_ready   = (state_r == ST_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt       = state_r;
    pkt_sel_nxt     = pkt_sel_r;
    byte_idx_nxt    = byte_idx_r;
    single_kind_nxt = single_kind_r;
    pkt_pend_nxt    = pkt_pend_r;
    drain_pend_nxt  = drain_pend_r;
    cmd             = '0;
    cmd.pkt_sel     = pkt_sel_r;
    cmd.byte_idx    = byte_idx_r;
    cmd.out_kind    = single_kind_r;
    cmd.out_src     = SRC_FRAME;

    case (state_r)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        byte_idx_nxt   = 3'd0;
        pkt_pend_nxt   = 1'b0;
        drain_pend_nxt = 1'b0;
        state_nxt      = ST_IDLE;
        case (status.op)
          OP_TICK: begin
            cmd.tick = !status.cd_zero;
            if (status.cd_one) begin
              pkt_sel_nxt = PKT_REQ;
              state_nxt   = ST_PKT;
            end
          end
          OP_CONTROL: begin
            cmd.restart_ack = status.ptype_req || status.ptype_conf;
            if (status.ptype_req) begin
              pkt_sel_nxt    = PKT_CONF;
              drain_pend_nxt = !status.q_empty;
              state_nxt      = ST_PKT;
            end else if ((status.ptype_conf || status.link_ready) && !status.q_empty) begin
              state_nxt = ST_DRAIN_RD;
            end
          end
          OP_SEND: begin
            cmd.link_update = 1'b1;
            if (status.link_ready && status.link_up) begin
              single_kind_nxt = KIND_DATA;
              state_nxt       = ST_SINGLE;
            end else begin
              cmd.enqueue  = !status.q_full;
              cmd.reload   = status.cd_zero;
              pkt_pend_nxt = status.cd_zero;
              pkt_sel_nxt  = PKT_REQ;
              if (status.q_full) begin
                single_kind_nxt = KIND_DROP;
                state_nxt       = ST_SINGLE;
              end else if (status.cd_zero) begin
                state_nxt = ST_PKT;
              end
            end
          end
          OP_DIAG: begin
            pkt_sel_nxt = PKT_DIAG;
            state_nxt   = ST_PKT;
          end
          OP_CLEAR: begin
            pkt_sel_nxt = PKT_CLEAR;
            state_nxt   = ST_PKT;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end

      // Emit a passed-through or dropped frame report
      ST_SINGLE: begin
        cmd.out_src  = SRC_FRAME;
        cmd.out_kind = single_kind_r;
        cmd.out_last = !pkt_pend_r;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = pkt_pend_r ? ST_PKT : ST_IDLE;
        end
      end

      // Emit control packet bytes one per transfer
      ST_PKT: begin
        cmd.out_src  = SRC_CTRL;
        cmd.out_kind = KIND_CTRL;
        cmd.out_last = pkt_at_end && !drain_pend_r;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (pkt_at_end) begin
            state_nxt = drain_pend_r ? ST_DRAIN_RD : ST_IDLE;
          end else begin
            byte_idx_nxt = byte_idx_r + 3'd1;
          end
        end
      end

      // Wait for the head slot to be read from the queue RAM
      ST_DRAIN_RD: begin
        state_nxt = ST_DRAIN_OUT;
      end

      // Release the oldest pending frame
      ST_DRAIN_OUT: begin
        cmd.out_src  = SRC_DRAIN;
        cmd.out_kind = KIND_DATA;
        cmd.out_last = status.q_one;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.pop      = 1'b1;
          state_nxt    = status.q_one ? ST_IDLE : ST_DRAIN_RD;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !status.q_empty)
    else $error("pop from empty queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enqueue |-> !status.q_full)
    else $error("enqueue into full queue");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over one not yet transferred");

  a_drain_link_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN_OUT) |-> status.link_ready)
    else $error("queue drained while link not ready");

endmodule

// ----- design/packet_layer_restart_controller.sv -----
// Top level of the packet layer restart controller: controller plus datapath.
// The input item is captured, then decided on, then each result is loaded into the output register;
// control bytes and frame reports are loaded one per transfer, and each drained frame passes through
// a read state and an output state (queue RAM registered read).
// A new input is taken once the item's final result, if any, is loaded into the output register.
// Reset (rst_n low, synchronous): link not ready, T20 idle, queue empty, configuration defaults.
module packet_layer_restart_controller #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [plrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [plrc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       in_op,
  input  logic [7:0]                       in_packet_type,
  input  logic [7:0]                       in_frame_handle,
  input  logic                             in_link_up,
  input  logic [7:0]                       in_diag_code,
  input  logic [11:0]                      in_channel_id,
  input  logic [7:0]                       in_clear_cause,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_kind,
  output logic [7:0]                       out_packet_byte,
  output logic [7:0]                       out_released_handle,
  output logic                             out_last
);
  import plrc_pkg::*;

  plrc_cmd_t    cmd;
  plrc_status_t status;

  plrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  plrc_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_op               (in_op),
    .in_packet_type      (in_packet_type),
    .in_frame_handle     (in_frame_handle),
    .in_link_up          (in_link_up),
    .in_diag_code        (in_diag_code),
    .in_channel_id       (in_channel_id),
    .in_clear_cause      (in_clear_cause),
    .cmd                 (cmd),
    .status              (status),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_packet_byte     (out_packet_byte),
    .out_released_handle (out_released_handle),
    .out_last            (out_last)
  );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the packet layer restart controller: table-driven and random traffic.
module tb;
  import plrc_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int SETTLE_CYC  = 48;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 8;
  localparam int MAX_LINES   = 40;
  localparam int PREDICTED   = -1;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  packet_type;
    logic [7:0]  frame_handle;
    logic        link_up;
    logic [7:0]  diag_code;
    logic [11:0] channel_id;
    logic [7:0]  clear_cause;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] pbyte;
    logic [7:0] handle;
    logic       last;
  } out_rec_t;

  // One row of the directed table; nb is PREDICTED or the number of typed control bytes
  typedef struct {
    in_item_t         it;
    int               nb;
    logic [4:0][7:0]  bytes;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic [7:0]  in_packet_type;
  logic [7:0]  in_frame_handle;
  logic        in_link_up;
  logic [7:0]  in_diag_code;
  logic [11:0] in_channel_id;
  logic [7:0]  in_clear_cause;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_packet_byte;
  logic [7:0]  out_released_handle;
  logic        out_last;

  // Predictor state and configuration copy
  logic        cfg_ext;
  logic [15:0] cfg_t20;
  logic        link_ok;
  logic [15:0] t20_count;
  logic [7:0]  hold_frames [QDEPTH];
  int          hold_head;
  int          hold_count;

  out_rec_t    step_out_q[$];
  out_rec_t    link_output_q[$];
  stim_row_t   rows[$];

  int              row_nb;
  logic [4:0][7:0] row_bytes;
  bit              calm;
  int              issued;
  int              mismatches;
  int              results_seen;
  int              cycles;

  packet_layer_restart_controller #(.QUEUE_DEPTH(QDEPTH)) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_packet_type      (in_packet_type),
    .in_frame_handle     (in_frame_handle),
    .in_link_up          (in_link_up),
    .in_diag_code        (in_diag_code),
    .in_channel_id       (in_channel_id),
    .in_clear_cause      (in_clear_cause),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_packet_byte     (out_packet_byte),
    .out_released_handle (out_released_handle),
    .out_last            (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_LINES) begin
      $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic void reset_model();
    cfg_ext    = 1'b0;
    cfg_t20    = RESTART_TIMEOUT_RESET;
    link_ok    = 1'b0;
    t20_count  = 16'd0;
    hold_head  = 0;
    hold_count = 0;
  endfunction

  function automatic void emit(kind_t k, logic [7:0] b, logic [7:0] h);
    out_rec_t r;
    r.kind   = k;
    r.pbyte  = b;
    r.handle = h;
    r.last   = 1'b0;
    step_out_q.push_back(r);
  endfunction

  function automatic void emit_restart_req(logic [7:0] g);
    emit(KIND_CTRL, g, 8'h00);
    emit(KIND_CTRL, 8'h00, 8'h00);
    emit(KIND_CTRL, PTYPE_RESTART_REQ, 8'h00);
    emit(KIND_CTRL, 8'h00, 8'h00);
    emit(KIND_CTRL, 8'h00, 8'h00);
  endfunction

  // Advance the link state by one item and collect the results it causes
  function automatic void restart_step(in_item_t it);
    logic [7:0] g;
    out_rec_t   r;
    g = cfg_ext ? GFI_MOD128 : GFI_MOD8;
    step_out_q.delete();
    case (it.op)
      OP_TICK: begin
        if (t20_count != 16'd0) begin
          t20_count = t20_count - 16'd1;
          // T20 expired: resend the request and reload
          if (t20_count == 16'd0) begin
            emit_restart_req(g);
            t20_count = cfg_t20;
          end
        end
      end
      OP_CONTROL: begin
        if (it.packet_type == PTYPE_RESTART_REQ || it.packet_type == PTYPE_RESTART_CONF) begin
          t20_count = 16'd0;
          link_ok   = 1'b1;
          if (it.packet_type == PTYPE_RESTART_REQ) begin
            emit(KIND_CTRL, g, 8'h00);
            emit(KIND_CTRL, 8'h00, 8'h00);
            emit(KIND_CTRL, PTYPE_RESTART_CONF, 8'h00);
          end
        end
        // Drain held frames, oldest first
        if (link_ok) begin
          while (hold_count > 0) begin
            emit(KIND_DATA, 8'h00, hold_frames[hold_head]);
            hold_head  = (hold_head + 1) % QDEPTH;
            hold_count = hold_count - 1;
          end
        end
      end
      OP_SEND: begin
        if (!it.link_up) link_ok = 1'b0;
        if (link_ok) begin
          emit(KIND_DATA, 8'h00, it.frame_handle);
        end else begin
          if (hold_count < QDEPTH) begin
            hold_frames[(hold_head + hold_count) % QDEPTH] = it.frame_handle;
            hold_count = hold_count + 1;
          end else begin
            emit(KIND_DROP, 8'h00, it.frame_handle);
          end
          if (t20_count == 16'd0) begin
            emit_restart_req(g);
            t20_count = cfg_t20;
          end
        end
      end
      OP_DIAG: begin
        emit(KIND_CTRL, g, 8'h00);
        emit(KIND_CTRL, 8'h00, 8'h00);
        emit(KIND_CTRL, PTYPE_DIAGNOSTIC, 8'h00);
        emit(KIND_CTRL, it.diag_code, 8'h00);
      end
      OP_CLEAR: begin
        // Channel group bits go into the low nibble of the GFI
        emit(KIND_CTRL, g | {4'h0, it.channel_id[11:8]}, 8'h00);
        emit(KIND_CTRL, it.channel_id[7:0], 8'h00);
        emit(KIND_CTRL, PTYPE_CLEAR_REQ, 8'h00);
        emit(KIND_CTRL, it.clear_cause, 8'h00);
        emit(KIND_CTRL, 8'h00, 8'h00);
      end
      default: begin
      end
    endcase
    if (step_out_q.size() > 0) begin
      r = step_out_q.pop_back();
      r.last = 1'b1;
      step_out_q.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- monitor

  // Check each result transfer, then queue what each input transfer causes
  always @(posedge clk) begin : watch_ports
    out_rec_t head;
    out_rec_t typed;
    in_item_t seen;
    int       j;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (link_output_q.size() == 0) begin
          report_mismatch("result with nothing owed, kind", int'(out_kind), 0);
        end else begin
          head = link_output_q.pop_front();
          if (out_kind !== head.kind)
            report_mismatch("kind", int'(out_kind), int'(head.kind));
          if (out_packet_byte !== head.pbyte)
            report_mismatch("packet_byte", int'(out_packet_byte), int'(head.pbyte));
          if (out_released_handle !== head.handle)
            report_mismatch("released_handle", int'(out_released_handle), int'(head.handle));
          if (out_last !== head.last)
            report_mismatch("last", int'(out_last), int'(head.last));
        end
      end
      if (in_valid && in_ready) begin
        seen.op           = in_op;
        seen.packet_type  = in_packet_type;
        seen.frame_handle = in_frame_handle;
        seen.link_up      = in_link_up;
        seen.diag_code    = in_diag_code;
        seen.channel_id   = in_channel_id;
        seen.clear_cause  = in_clear_cause;
        restart_step(seen);
        if (row_nb == PREDICTED) begin
          for (j = 0; j < step_out_q.size(); j++) link_output_q.push_back(step_out_q[j]);
        end else begin
          // Typed rows list control bytes first byte at the top of the vector
          for (j = 0; j < row_nb; j++) begin
            typed.kind   = KIND_CTRL;
            typed.pbyte  = row_bytes[4-j];
            typed.handle = 8'h00;
            typed.last   = (j == row_nb - 1);
            link_output_q.push_back(typed);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // Present one item after a random gap and hold it until the transfer
  task automatic send_item(input in_item_t it, input int nb, input logic [4:0][7:0] bytes);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_op           = it.op;
    in_packet_type  = it.packet_type;
    in_frame_handle = it.frame_handle;
    in_link_up      = it.link_up;
    in_diag_code    = it.diag_code;
    in_channel_id   = it.channel_id;
    in_clear_cause  = it.clear_cause;
    row_nb          = nb;
    row_bytes       = bytes;
    in_valid        = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off input until every owed result is out and the block has gone quiet
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (link_output_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_EXTENDED_SEQ) cfg_ext = val[0];
    else cfg_t20 = val;
  endtask

  // Random stall before each result transfer
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = calm ? 0 : $urandom_range(0, 9);
      while (stall > 0) begin
        out_ready = 1'b0;
        @(negedge clk);
        stall--;
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic stim_row_t mk(logic [2:0] op, logic [7:0] ptype, logic [7:0] handle,
                                   logic up, logic [7:0] diag, logic [11:0] lci,
                                   logic [7:0] cause, int nb, logic [4:0][7:0] bytes);
    stim_row_t r;
    r.it.op           = op;
    r.it.packet_type  = ptype;
    r.it.frame_handle = handle;
    r.it.link_up      = up;
    r.it.diag_code    = diag;
    r.it.channel_id   = lci;
    r.it.clear_cause  = cause;
    r.nb              = nb;
    r.bytes           = bytes;
    return r;
  endfunction

  // Directed table: runs with modulo-8 GFI and a T20 reload of one tick
  task automatic build_rows();
    int         i;
    logic [7:0] h;
    rows.push_back(mk(OP_TICK, 8'h00, 8'h00, 1'b0, 8'h00, 12'h000, 8'h00, 0, '0));
    rows.push_back(mk(OP_SPARE_LO, 8'hFF, 8'hFF, 1'b1, 8'hFF, 12'hFFF, 8'hFF, 0, '0));
    rows.push_back(mk(OP_SPARE_HI, 8'h00, 8'h00, 1'b0, 8'h00, 12'h000, 8'h00, 0, '0));
    rows.push_back(mk(OP_DIAG, 8'h00, 8'h00, 1'b0, 8'h00, 12'h000, 8'h00, 4,
                      {GFI_MOD8, 8'h00, PTYPE_DIAGNOSTIC, 8'h00, 8'h00}));
    rows.push_back(mk(OP_DIAG, 8'h00, 8'h00, 1'b0, 8'hFF, 12'h000, 8'h00, 4,
                      {GFI_MOD8, 8'h00, PTYPE_DIAGNOSTIC, 8'hFF, 8'h00}));
    rows.push_back(mk(OP_CLEAR, 8'h00, 8'h00, 1'b0, 8'h00, 12'h000, 8'h00, 5,
                      {GFI_MOD8, 8'h00, PTYPE_CLEAR_REQ, 8'h00, 8'h00}));
    rows.push_back(mk(OP_CLEAR, 8'h00, 8'h00, 1'b0, 8'h00, 12'hFFF, 8'hFF, 5,
                      {GFI_MOD8 | 8'h0F, 8'hFF, PTYPE_CLEAR_REQ, 8'hFF, 8'h00}));
    // Unrelated packet type while not restarted: nothing happens
    rows.push_back(mk(OP_CONTROL, 8'h00, 8'h00, 1'b0, 8'h00, 12'h000, 8'h00, PREDICTED, '0));
    // First frame while down: queue it and send the restart request
    rows.push_back(mk(OP_SEND, 8'h00, 8'h00, 1'b0, 8'h00, 12'h000, 8'h00, 5,
                      {GFI_MOD8, 8'h00, PTYPE_RESTART_REQ, 8'h00, 8'h00}));
    // T20 runs out after one tick: resend the request
    rows.push_back(mk(OP_TICK, 8'h00, 8'h00, 1'b0, 8'h00, 12'h000, 8'h00, 5,
                      {GFI_MOD8, 8'h00, PTYPE_RESTART_REQ, 8'h00, 8'h00}));
    // Fill the queue, then overflow it
    for (i = 1; i < QDEPTH; i++) begin
      h = 8'(i * 17);
      rows.push_back(mk(OP_SEND, 8'h00, h, 1'b1, 8'h00, 12'h000, 8'h00, PREDICTED, '0));
    end
    rows.push_back(mk(OP_SEND, 8'h00, 8'hA5, 1'b1, 8'h00, 12'h000, 8'h00, PREDICTED, '0));
    // Peer restart request: confirm and drain the full queue
    rows.push_back(mk(OP_CONTROL, PTYPE_RESTART_REQ, 8'h00, 1'b1, 8'h00, 12'h000, 8'h00,
                      PREDICTED, '0));
    rows.push_back(mk(OP_SEND, 8'h00, 8'h5A, 1'b1, 8'h00, 12'h000, 8'h00, PREDICTED, '0));
    rows.push_back(mk(OP_CONTROL, PTYPE_DIAGNOSTIC, 8'h00, 1'b0, 8'h00, 12'h000, 8'h00,
                      PREDICTED, '0));
  endtask

  function automatic in_item_t rand_item(logic [2:0] op);
    in_item_t it;
    it.op           = op;
    it.packet_type  = 8'($urandom_range(0, 255));
    it.frame_handle = 8'($urandom_range(0, 255));
    it.link_up      = 1'($urandom_range(0, 1));
    it.diag_code    = 8'($urandom_range(0, 255));
    it.channel_id   = 12'($urandom_range(0, 4095));
    it.clear_cause  = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Send one random item, now and then waiting for the block to empty first
  task automatic issue(input in_item_t it);
    if ($urandom_range(0, 99) < 3) settle();
    send_item(it, PREDICTED, '0);
    if (it.op <= OP_CLEAR) issued++;
  endtask

  task automatic random_episode();
    in_item_t it;
    int       k;
    k = $urandom_range(0, 99);
    if (k < 25) begin
      // Link outage: frames pile up, timer ticks, then the peer restarts
      it = rand_item(OP_SEND);
      it.link_up = 1'b0;
      issue(it);
      repeat ($urandom_range(2, 18)) begin
        it = rand_item(OP_SEND);
        it.link_up = 1'b1;
        issue(it);
      end
      repeat ($urandom_range(0, 4)) issue(rand_item(OP_TICK));
      it = rand_item(OP_CONTROL);
      it.packet_type = $urandom_range(0, 1) ? PTYPE_RESTART_REQ : PTYPE_RESTART_CONF;
      issue(it);
    end else if (k < 50) begin
      issue(rand_item(OP_TICK));
    end else if (k < 70) begin
      it = rand_item(OP_SEND);
      it.link_up = ($urandom_range(0, 99) < 85);
      issue(it);
    end else if (k < 82) begin
      it = rand_item(OP_CONTROL);
      if ($urandom_range(0, 1))
        it.packet_type = $urandom_range(0, 1) ? PTYPE_RESTART_REQ : PTYPE_RESTART_CONF;
      issue(it);
    end else if (k < 89) begin
      issue(rand_item(OP_DIAG));
    end else if (k < 96) begin
      issue(rand_item(OP_CLEAR));
    end else begin
      issue(rand_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))));
    end
  endtask

  task automatic run_phase(input logic ext, input logic [15:0] t20, input bit quiet);
    int goal;
    settle();
    write_reg(CFG_EXTENDED_SEQ, {15'd0, ext});
    write_reg(CFG_RESTART_TIMEOUT, t20);
    calm = quiet;
    goal = issued + PHASE_ITEMS;
    while (issued < goal) random_episode();
  endtask

  initial begin : stimulus
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_EXTENDED_SEQ;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_op           = OP_TICK;
    in_packet_type  = 8'h00;
    in_frame_handle = 8'h00;
    in_link_up      = 1'b0;
    in_diag_code    = 8'h00;
    in_channel_id   = 12'h000;
    in_clear_cause  = 8'h00;
    row_nb          = PREDICTED;
    row_bytes       = '0;
    calm            = 1'b0;
    issued          = 0;
    mismatches      = 0;
    results_seen    = 0;
    reset_model();
    build_rows();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_reg(CFG_RESTART_TIMEOUT, 16'd1);
    foreach (rows[i]) send_item(rows[i].it, rows[i].nb, rows[i].bytes);

    run_phase(1'b1, 16'd3, 1'b1);
    run_phase(1'b0, 16'hFFFF, 1'b0);
    run_phase(1'b1, 16'd1, 1'b0);
    run_phase(1'($urandom_range(0, 1)), 16'($urandom_range(2, 8)), 1'b0);
    run_phase(1'b0, 16'd2, 1'b0);
    settle();

    if (link_output_q.size() != 0)
      report_mismatch("results never produced, count", 0, link_output_q.size());
    if (mismatches == 0) begin
      $display("packet_layer_restart_controller regression: pass");
    end else begin
      $display("packet_layer_restart_controller regression: fail");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("packet_layer_restart_controller regression: fail");
    $finish;
  end

endmodule

// ----- packet_layer_restart_controller.f -----
design/plrc_pkg.sv
design/plrc_ram.sv
design/plrc_dp.sv
design/plrc_ctrl.sv
design/packet_layer_restart_controller.sv
tb/tb.sv
